// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the datapath. Both sample on clk and are
// disabled while rst_n is low, so they expect those names in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every sampled edge
`define STLI_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Antecedent implies consequent in the same cycle
`define STLI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define STLI_ASSERT(lbl, prop)
`define STLI_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// ===== rtl/stli_pkg.sv =====
package stli_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 16;

    // Command codes
    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_RANGE = 3'd1,
        ST_FEW   = 3'd2,
        ST_FULL  = 3'd3,
        ST_SAT   = 3'd4
    } status_t;

    // Request and response payloads
    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [15:0] angle_in;
        logic signed [15:0] coef_in;
    } req_t;

    typedef struct packed {
        logic signed [15:0] coef_out;
        logic [2:0]         status;
        logic [4:0]         entry_count;
    } rsp_t;

    // Datapath command fields
    typedef enum logic [2:0] {
        IDX_HOLD = 3'd0,
        IDX_CLR  = 3'd1,
        IDX_LAST = 3'd2,
        IDX_INC  = 3'd3,
        IDX_DEC  = 3'd4
    } idx_op_t;

    typedef enum logic [1:0] {
        WR_NONE   = 2'd0,
        WR_SHIFT  = 2'd1,
        WR_NEW_UP = 2'd2,
        WR_NEW_AT = 2'd3
    } wr_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD = 2'd0,
        CNT_CLR  = 2'd1,
        CNT_INC  = 2'd2
    } cnt_op_t;

    typedef enum logic [1:0] {
        RES_ZERO   = 2'd0,
        RES_COEF   = 2'd1,
        RES_INTERP = 2'd2
    } res_sel_t;

    typedef struct packed {
        logic     item_load;
        idx_op_t  idx_op;
        wr_op_t   wr_op;
        cnt_op_t  cnt_op;
        logic     prev_load;
        logic     brk_load;
        logic     mul_load;
        logic     div_start;
        logic     res_load;
        res_sel_t res_sel;
        status_t  res_st;
        logic     out_load;
    } dp_ctrl_t;

    typedef struct packed {
        cmd_t cmd;
        logic full;
        logic few;
        logic count_zero;
        logic idx_zero;
        logic idx_last;
        logic rd_gt;
        logic rd_eq;
        logic div_busy;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== rtl/sorted_table_linear_interpolator_unit.sv =====
// Sorted breakpoint table with linear interpolation. Each request carries a
// command: clear the table, append an (angle Q8.8, coefficient Q4.12) pair,
// or query an angle; every request yields exactly one response with the
// coefficient, a status code and the entry count afterwards. Pairs are kept
// in ascending angle order, equal angles in load order. One request is in
// work at a time; the response sits in an output register, so the next
// request is taken while it waits. Clear, the unused command, an append to
// a full table and a query with too few points answer without a table walk;
// other appends move each larger entry up one slot (up to TABLE_DEPTH - 1)
// and then write the new pair; other queries scan entries upward (up to
// TABLE_DEPTH), then multiply and divide when they interpolate. The table
// walk is single-port, one entry a cycle, and the divider is the 16-step
// serial one. No clearing pass after reset.
module sorted_table_linear_interpolator_unit
    import stli_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    dp_ctrl_t ctrl;
    dp_stat_t stat;

    // Sequencer
    stli_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    // Table, arithmetic and response register
    stli_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .ctrl      (ctrl),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

// ===== rtl/stli_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
// Caller guarantees dividend < divisor * 2^16, so the quotient fits 16 bits.
module stli_div
    import stli_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        busy,
    output logic [15:0] quotient
);

    logic [4:0]  cnt_reg;
    logic [15:0] rem_reg;
    logic [15:0] shf_reg;
    logic [15:0] dsr_reg;
    logic [16:0] trial;
    logic        qbit;

    // Trial subtract of the shifted partial remainder
    always_comb
    begin
        trial = {rem_reg, shf_reg[15]};
        qbit  = (trial >= {1'b0, dsr_reg});
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= 5'd16;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 5'd1;
        end
    end

    // Remainder and dividend/quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[31:16];
            shf_reg <= dividend[15:0];
            dsr_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= qbit ? 16'(trial - {1'b0, dsr_reg}) : trial[15:0];
            shf_reg <= {shf_reg[14:0], qbit};
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = shf_reg;

endmodule

// ===== rtl/stli_datapath.sv =====
`include "assert_macros.svh"
module stli_datapath
    import stli_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  req_t     req,
    input  dp_ctrl_t ctrl,
    output dp_stat_t stat,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output rsp_t     rsp
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    req_t               item_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [IW-1:0]      idx_reg;
    logic [IW-1:0]      idx_next;
    logic [IW-1:0]      idx_up;

    logic signed [15:0] angle_mem [TABLE_DEPTH];
    logic signed [15:0] coef_mem  [TABLE_DEPTH];
    logic signed [15:0] rd_angle_reg;
    logic signed [15:0] rd_coef_reg;

    logic signed [15:0] q_angle;
    logic signed [15:0] prev_angle_reg;
    logic signed [15:0] prev_coef_reg;
    logic signed [16:0] dq_reg;
    logic signed [16:0] dc_reg;
    logic [15:0]        den_reg;
    logic signed [15:0] c0_reg;
    logic signed [33:0] prod_reg;
    logic [33:0]        prod_mag;
    logic               neg_reg;

    logic               div_busy;
    logic [15:0]        div_quo;
    logic signed [17:0] quo_s;
    logic signed [17:0] sum_v;
    logic signed [15:0] interp_coef;
    logic               interp_sat;

    logic signed [15:0] res_coef_reg;
    status_t            res_st_reg;
    logic               rsp_valid_reg;
    rsp_t               rsp_reg;
    logic               out_free;

    assign q_angle = item_reg.angle_in;

    // Latch the accepted request
    always_ff @(posedge clk)
    begin
        if (ctrl.item_load)
        begin
            item_reg <= req;
        end
    end

    // Table index: the read port always fetches the entry idx will point at
    always_comb
    begin
        unique case (ctrl.idx_op)
            IDX_HOLD: idx_next = idx_reg;
            IDX_CLR:  idx_next = '0;
            IDX_LAST: idx_next = IW'(count_reg - 1'b1);
            IDX_INC:  idx_next = idx_reg + 1'b1;
            IDX_DEC:  idx_next = idx_reg - 1'b1;
            default:  idx_next = idx_reg;
        endcase
    end

    assign idx_up = idx_reg + 1'b1;

    // Entry count
    always_comb
    begin
        unique case (ctrl.cnt_op)
            CNT_HOLD: count_next = count_reg;
            CNT_CLR:  count_next = '0;
            CNT_INC:  count_next = count_reg + 1'b1;
            default:  count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            idx_reg   <= idx_next;
            count_reg <= count_next;
        end
    end

    // Breakpoint memories: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        unique case (ctrl.wr_op)
            WR_NONE:
            begin
            end
            WR_SHIFT:
            begin
                angle_mem[idx_up] <= rd_angle_reg;
                coef_mem[idx_up]  <= rd_coef_reg;
            end
            WR_NEW_UP:
            begin
                angle_mem[idx_up] <= item_reg.angle_in;
                coef_mem[idx_up]  <= item_reg.coef_in;
            end
            WR_NEW_AT:
            begin
                angle_mem[idx_reg] <= item_reg.angle_in;
                coef_mem[idx_reg]  <= item_reg.coef_in;
            end
        endcase
        rd_angle_reg <= angle_mem[idx_next];
        rd_coef_reg  <= coef_mem[idx_next];
    end

    // Lower breakpoint and bracket differences
    always_ff @(posedge clk)
    begin
        if (ctrl.prev_load)
        begin
            prev_angle_reg <= rd_angle_reg;
            prev_coef_reg  <= rd_coef_reg;
        end
        if (ctrl.brk_load)
        begin
            dq_reg  <= 17'(q_angle) - 17'(prev_angle_reg);
            dc_reg  <= 17'(rd_coef_reg) - 17'(prev_coef_reg);
            den_reg <= 16'(17'(rd_angle_reg) - 17'(prev_angle_reg));
            c0_reg  <= prev_coef_reg;
        end
        if (ctrl.mul_load)
        begin
            prod_reg <= dq_reg * dc_reg;
        end
        if (ctrl.div_start)
        begin
            neg_reg <= prod_reg[33];
        end
    end

    // Divide the product magnitude by the angle span
    assign prod_mag = prod_reg[33] ? 34'(-prod_reg) : 34'(prod_reg);

    stli_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.div_start),
        .dividend (prod_mag[31:0]),
        .divisor  (den_reg),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // Apply sign, add base coefficient and clamp to 16 bits
    always_comb
    begin
        quo_s = neg_reg ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
        sum_v = 18'(c0_reg) + quo_s;
        if (sum_v > 18'sd32767)
        begin
            interp_coef = 16'sh7FFF;
            interp_sat  = 1'b1;
        end
        else if (sum_v < -18'sd32768)
        begin
            interp_coef = 16'sh8000;
            interp_sat  = 1'b1;
        end
        else
        begin
            interp_coef = sum_v[15:0];
            interp_sat  = 1'b0;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (ctrl.res_load)
        begin
            unique case (ctrl.res_sel)
                RES_ZERO:
                begin
                    res_coef_reg <= '0;
                    res_st_reg   <= ctrl.res_st;
                end
                RES_COEF:
                begin
                    res_coef_reg <= rd_coef_reg;
                    res_st_reg   <= ctrl.res_st;
                end
                RES_INTERP:
                begin
                    res_coef_reg <= interp_coef;
                    res_st_reg   <= interp_sat ? ST_SAT : ctrl.res_st;
                end
                default:
                begin
                    res_coef_reg <= '0;
                    res_st_reg   <= ctrl.res_st;
                end
            endcase
        end
    end

    // Output register, frees the datapath while a response waits
    assign out_free = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (ctrl.out_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            rsp_reg.coef_out    <= res_coef_reg;
            rsp_reg.status      <= res_st_reg;
            rsp_reg.entry_count <= 5'(count_reg);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Status to the controller
    always_comb
    begin
        stat.cmd        = cmd_t'(item_reg.cmd);
        stat.full       = (count_reg >= DEPTH_C);
        stat.few        = (count_reg < CW'(2));
        stat.count_zero = (count_reg == '0);
        stat.idx_zero   = (idx_reg == '0);
        stat.idx_last   = ((CW'(idx_reg) + 1'b1) == count_reg);
        stat.rd_gt      = (rd_angle_reg > q_angle);
        stat.rd_eq      = (rd_angle_reg == q_angle);
        stat.div_busy   = div_busy;
        stat.out_free   = out_free;
    end

    `STLI_ASSERT(a_count_bound, count_reg <= DEPTH_C)
    `STLI_ASSERT_IMP(a_write_not_full, ctrl.wr_op != WR_NONE, count_reg < DEPTH_C)
    `STLI_ASSERT_IMP(a_no_overwrite, ctrl.out_load, out_free)
    `STLI_ASSERT_IMP(a_div_idle_start, ctrl.div_start, !div_busy)

endmodule

// ===== rtl/stli_ctrl.sv =====
module stli_ctrl
    import stli_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  dp_stat_t stat,
    output dp_ctrl_t ctrl
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_A_CMP,
        S_A_INS,
        S_Q_SCAN,
        S_Q_MUL,
        S_Q_DIVGO,
        S_Q_DIV,
        S_Q_FIN,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and datapath commands
    always_comb
    begin
        state_next    = state_reg;
        ctrl          = '0;
        ctrl.idx_op   = IDX_HOLD;
        ctrl.wr_op    = WR_NONE;
        ctrl.cnt_op   = CNT_HOLD;
        ctrl.res_sel  = RES_ZERO;
        ctrl.res_st   = ST_OK;
        req_ready     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ctrl.item_load = 1'b1;
                    state_next     = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (stat.cmd)
                    CMD_CLEAR:
                    begin
                        ctrl.cnt_op   = CNT_CLR;
                        ctrl.res_load = 1'b1;
                        state_next    = S_RESP;
                    end
                    CMD_APPEND:
                    begin
                        if (stat.full)
                        begin
                            ctrl.res_load = 1'b1;
                            ctrl.res_st   = ST_FULL;
                            state_next    = S_RESP;
                        end
                        else if (stat.count_zero)
                        begin
                            ctrl.idx_op = IDX_CLR;
                            state_next  = S_A_INS;
                        end
                        else
                        begin
                            ctrl.idx_op = IDX_LAST;
                            state_next  = S_A_CMP;
                        end
                    end
                    CMD_QUERY:
                    begin
                        if (stat.few)
                        begin
                            ctrl.res_load = 1'b1;
                            ctrl.res_st   = ST_FEW;
                            state_next    = S_RESP;
                        end
                        else
                        begin
                            ctrl.idx_op = IDX_CLR;
                            state_next  = S_Q_SCAN;
                        end
                    end
                    CMD_NOP:
                    begin
                        ctrl.res_load = 1'b1;
                        state_next    = S_RESP;
                    end
                endcase
            end
            // Insertion: move larger entries up one slot, top entry first
            S_A_CMP:
            begin
                if (stat.rd_gt)
                begin
                    ctrl.wr_op = WR_SHIFT;
                    if (stat.idx_zero)
                    begin
                        state_next = S_A_INS;
                    end
                    else
                    begin
                        ctrl.idx_op = IDX_DEC;
                    end
                end
                else
                begin
                    ctrl.wr_op    = WR_NEW_UP;
                    ctrl.cnt_op   = CNT_INC;
                    ctrl.res_load = 1'b1;
                    state_next    = S_RESP;
                end
            end
            S_A_INS:
            begin
                ctrl.wr_op    = WR_NEW_AT;
                ctrl.cnt_op   = CNT_INC;
                ctrl.res_load = 1'b1;
                state_next    = S_RESP;
            end
            // Walk upward: first equal entry wins, first larger one brackets
            S_Q_SCAN:
            begin
                if (stat.rd_eq)
                begin
                    ctrl.res_load = 1'b1;
                    ctrl.res_sel  = RES_COEF;
                    state_next    = S_RESP;
                end
                else if (stat.rd_gt)
                begin
                    if (stat.idx_zero)
                    begin
                        ctrl.res_load = 1'b1;
                        ctrl.res_st   = ST_RANGE;
                        state_next    = S_RESP;
                    end
                    else
                    begin
                        ctrl.brk_load = 1'b1;
                        state_next    = S_Q_MUL;
                    end
                end
                else if (stat.idx_last)
                begin
                    ctrl.res_load = 1'b1;
                    ctrl.res_st   = ST_RANGE;
                    state_next    = S_RESP;
                end
                else
                begin
                    ctrl.prev_load = 1'b1;
                    ctrl.idx_op    = IDX_INC;
                end
            end
            S_Q_MUL:
            begin
                ctrl.mul_load = 1'b1;
                state_next    = S_Q_DIVGO;
            end
            S_Q_DIVGO:
            begin
                ctrl.div_start = 1'b1;
                state_next     = S_Q_DIV;
            end
            S_Q_DIV:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_Q_FIN;
                end
            end
            S_Q_FIN:
            begin
                ctrl.res_load = 1'b1;
                ctrl.res_sel  = RES_INTERP;
                state_next    = S_RESP;
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== dv/sorted_table_linear_interpolator_unit_test.sv =====
module sorted_table_linear_interpolator_unit_test;

    import stli_pkg::*;

    localparam int DEPTH      = TABLE_DEPTH_DEFAULT;
    localparam int RAND_ITEMS = 1000;
    localparam int STALL_MAX  = 4000;
    localparam int DRAIN      = 80;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    // Requests waiting to be driven, responses still owed by the block
    req_t cmd_backlog[$];
    rsp_t answers_due[$];

    // Shadow of the breakpoint table, updated on every request transfer
    int tbl_angle[DEPTH];
    int tbl_coef[DEPTH];
    int tbl_count;

    // Angles loaded since the last clear, seen by the generator only
    int gen_angles[$];
    int item_total;

    int mismatches;
    int idle_cycles;
    logic req_xfer;

    // Driver pacing
    int req_gap;
    int rsp_stall;
    int calm_left;
    logic calm;

    sorted_table_linear_interpolator_unit #(
        .TABLE_DEPTH(DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Apply one request to the shadow table and return the response it earns
    function automatic rsp_t table_apply(req_t r);
        rsp_t o;
        int pos;
        int i;
        int q;
        logic found;
        longint num;
        longint den;
        longint v;
        o.coef_out = '0;
        o.status = ST_OK;
        q = $signed(r.angle_in);
        case (cmd_t'(r.cmd))
            CMD_CLEAR:
            begin
                tbl_count = 0;
            end
            CMD_APPEND:
            begin
                if (tbl_count >= DEPTH)
                    o.status = ST_FULL;
                else
                begin
                    // insert after every angle <= new one, keeps load order on ties
                    pos = tbl_count;
                    while (pos > 0 && tbl_angle[pos-1] > q)
                    begin
                        tbl_angle[pos] = tbl_angle[pos-1];
                        tbl_coef[pos] = tbl_coef[pos-1];
                        pos--;
                    end
                    tbl_angle[pos] = q;
                    tbl_coef[pos] = $signed(r.coef_in);
                    tbl_count++;
                end
            end
            CMD_QUERY:
            begin
                if (tbl_count < 2)
                    o.status = ST_FEW;
                else if (q < tbl_angle[0] || q > tbl_angle[tbl_count-1])
                    o.status = ST_RANGE;
                else
                begin
                    found = 1'b0;
                    // exact hit: earliest loaded entry wins
                    for (i = 0; i < tbl_count; i++)
                    begin
                        if (!found && tbl_angle[i] == q)
                        begin
                            o.coef_out = tbl_coef[i][15:0];
                            found = 1'b1;
                        end
                    end
                    // strict bracket, quotient truncates toward zero
                    for (i = 0; i + 1 < tbl_count; i++)
                    begin
                        if (!found && tbl_angle[i] < q && q < tbl_angle[i+1])
                        begin
                            den = longint'(tbl_angle[i+1]) - tbl_angle[i];
                            num = (longint'(q) - tbl_angle[i]) *
                                  (longint'(tbl_coef[i+1]) - tbl_coef[i]);
                            v = longint'(tbl_coef[i]) + num / den;
                            if (v > 32767)
                            begin
                                v = 32767;
                                o.status = ST_SAT;
                            end
                            else if (v < -32768)
                            begin
                                v = -32768;
                                o.status = ST_SAT;
                            end
                            o.coef_out = v[15:0];
                            found = 1'b1;
                        end
                    end
                    if (!found)
                        o.status = ST_RANGE;
                end
            end
            default:
            begin
            end
        endcase
        o.entry_count = tbl_count[4:0];
        return o;
    endfunction

    function automatic int rand16();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    // Idle length: none when quiet, else mostly none or short, now and then long
    function automatic int pick_gap(logic quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic add_item(input cmd_t op, input int ang, input int cf);
        req_t r;
        r.cmd = op;
        r.angle_in = ang[15:0];
        r.coef_in = cf[15:0];
        cmd_backlog = {cmd_backlog, r};
        item_total++;
        if (op == CMD_CLEAR)
            gen_angles.delete();
        else if (op == CMD_APPEND && gen_angles.size() < DEPTH)
            gen_angles = {gen_angles, ang};
    endtask

    // One well-formed burst: optional clear, a few appends, queries, now and then an unused command
    task automatic add_sequence();
        int npts;
        int nq;
        int mode;
        int base;
        int span;
        int lo;
        int hi;
        int q;
        int k;
        int r;
        int ang;
        int ext[$];
        if ($urandom_range(0, 9) != 0)
            add_item(CMD_CLEAR, rand16(), rand16());
        r = $urandom_range(0, 19);
        if (r == 0)
            npts = $urandom_range(0, 1);
        else if (r < 14)
            npts = $urandom_range(2, 6);
        else if (r < 18)
            npts = $urandom_range(7, 16);
        else
            npts = $urandom_range(17, 20);
        mode = $urandom_range(0, 2);
        base = rand16();
        span = (mode == 1) ? $urandom_range(1, 8) : $urandom_range(16, 4000);
        for (k = 0; k < npts; k++)
        begin
            if ($urandom_range(0, 19) == 0)
                ang = $urandom_range(0, 1) ? 32767 : -32768;
            else if (mode == 0)
                ang = rand16();
            else
            begin
                ang = base + int'($urandom_range(0, span));
                if (ang > 32767)
                    ang = 32767;
            end
            add_item(CMD_APPEND, ang, rand16());
        end
        nq = $urandom_range(1, 10);
        for (k = 0; k < nq; k++)
        begin
            if (gen_angles.size() == 0)
                q = rand16();
            else
            begin
                ext = gen_angles.min();
                lo = ext[0];
                ext = gen_angles.max();
                hi = ext[0];
                r = $urandom_range(0, 99);
                if (r < 55)
                    q = lo + int'($urandom_range(0, hi - lo));
                else if (r < 75)
                    q = gen_angles[$urandom_range(0, gen_angles.size() - 1)];
                else if (r < 85)
                begin
                    q = lo - int'($urandom_range(1, 50));
                    if (q < -32768)
                        q = -32768;
                end
                else if (r < 95)
                begin
                    q = hi + int'($urandom_range(1, 50));
                    if (q > 32767)
                        q = 32767;
                end
                else
                    q = rand16();
            end
            add_item(CMD_QUERY, q, rand16());
        end
        if ($urandom_range(0, 9) == 0)
            add_item(CMD_NOP, rand16(), rand16());
    endtask

    // Stimulus, reset and end of run
    initial
    begin
        int k;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_ready = 1'b0;
        mismatches = 0;
        tbl_count = 0;
        item_total = 0;
        req_gap = 0;
        rsp_stall = 0;
        calm_left = 0;
        calm = 1'b0;

        // empty table, then unused command with all field bits set
        add_item(CMD_QUERY, 0, 0);
        add_item(CMD_NOP, -1, -1);
        // single point: exact angle still reports too few points
        add_item(CMD_APPEND, 100, 32767);
        add_item(CMD_QUERY, 100, 0);
        // out-of-order append lands in front
        add_item(CMD_APPEND, -100, -32768);
        add_item(CMD_QUERY, -101, 0);
        add_item(CMD_QUERY, 101, 0);
        add_item(CMD_QUERY, 100, 0);
        add_item(CMD_QUERY, 37, 0);
        // duplicate angles: exact match picks first loaded, bracket is strict
        add_item(CMD_APPEND, 0, 0);
        add_item(CMD_APPEND, 0, 4660);
        add_item(CMD_QUERY, 0, 0);
        add_item(CMD_QUERY, 1, 0);
        add_item(CMD_QUERY, -1, 0);
        // extreme angles, fill to capacity, then one append too many
        add_item(CMD_APPEND, -32768, 1);
        add_item(CMD_APPEND, 32767, -1);
        add_item(CMD_QUERY, -32768, 0);
        add_item(CMD_QUERY, 32767, 0);
        for (k = 0; k < DEPTH - 6; k++)
            add_item(CMD_APPEND, rand16(), rand16());
        add_item(CMD_APPEND, 5, 5);
        add_item(CMD_QUERY, rand16(), 0);
        add_item(CMD_CLEAR, 0, 0);

        k = item_total + RAND_ITEMS;
        while (item_total < k)
            add_sequence();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // checked at the rising edge, after the driver's updates have settled
        while (cmd_backlog.size() != 0 || req_valid || answers_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (mismatches == 0 && answers_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Drive both sides at the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            // alternate between quiet stretches and randomly paced ones
            if (calm_left == 0)
            begin
                calm = ($urandom_range(0, 3) == 0);
                calm_left = $urandom_range(50, 300);
            end
            else
                calm_left--;

            // request side: hold until transfer, then gap or next item
            if (!(req_valid && !req_xfer))
            begin
                if (req_xfer)
                    req_gap = pick_gap(calm);
                if (req_gap > 0)
                begin
                    req_gap--;
                    req_valid <= 1'b0;
                end
                else if (cmd_backlog.size() > 0)
                begin
                    req <= cmd_backlog.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end

            // response side backpressure
            if (rsp_stall > 0)
            begin
                rsp_stall--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    rsp_stall = pick_gap(calm);
            end
        end
    end

    // Sample transfers at the rising edge, predict and compare
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            req_xfer <= 1'b0;
            idle_cycles <= 0;
        end
        else
        begin
            req_xfer <= req_valid && req_ready;

            if (rsp_valid && rsp_ready)
            begin
                if (answers_due.size() == 0)
                begin
                    $display("%0t: response with none outstanding: coef %0d status %0d count %0d",
                             $time, rsp.coef_out, rsp.status, rsp.entry_count);
                    mismatches++;
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (rsp.coef_out !== want.coef_out)
                    begin
                        $display("%0t: coef_out expected %0d, got %0d",
                                 $time, want.coef_out, rsp.coef_out);
                        mismatches++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, rsp.status);
                        mismatches++;
                    end
                    if (rsp.entry_count !== want.entry_count)
                    begin
                        $display("%0t: entry_count expected %0d, got %0d",
                                 $time, want.entry_count, rsp.entry_count);
                        mismatches++;
                    end
                end
            end

            if (req_valid && req_ready)
                answers_due = {answers_due, table_apply(req)};

            // watchdog on cycles without any transfer
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_MAX)
            begin
                $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                $display("FAILURE");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/stli_pkg.sv
rtl/stli_div.sv
rtl/stli_datapath.sv
rtl/stli_ctrl.sv
rtl/sorted_table_linear_interpolator_unit.sv
dv/sorted_table_linear_interpolator_unit_test.sv
